[hdl/text_component_stats_filter_macros.svh]
`ifndef TEXT_COMPONENT_STATS_FILTER_MACROS_SVH
`define TEXT_COMPONENT_STATS_FILTER_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset
`define TCSF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock outside reset
`define TCSF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/tcsf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tcsf_pkg;

   // Controller states
   typedef enum logic [3:0] {
      ST_ACC,
      ST_L1,
      ST_P1,
      ST_L2,
      ST_P2,
      ST_L3,
      ST_P3,
      ST_PROD1,
      ST_PROD2,
      ST_OUT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic acc;
      logic clear;
      logic load1;
      logic step1;
      logic load2;
      logic step2;
      logic load3;
      logic prod1;
      logic prod2;
      logic out_load;
   } cmd_type;

   // Configuration registers
   typedef struct packed {
      logic [15:0] min_aspect;
      logic [15:0] max_aspect;
      logic [16:0] min_fill;
      logic [16:0] max_fill;
      logic [15:0] var_mean_ratio;
   } csr_type;

   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 17;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_ASPECT     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_ASPECT     = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_FILL       = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_FILL       = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VAR_MEAN_RATIO = 3'd4;

   localparam logic [15:0] RST_MIN_ASPECT     = 16'd26;
   localparam logic [15:0] RST_MAX_ASPECT     = 16'd2560;
   localparam logic [16:0] RST_MIN_FILL       = 17'd6554;
   localparam logic [16:0] RST_MAX_FILL       = 17'd58982;
   localparam logic [15:0] RST_VAR_MEAN_RATIO = 16'd512;

   localparam int SW_BITS    = 16;
   localparam int COLOR_BITS = 8;
   localparam int MEAN_BITS  = 16;
   localparam int VAR_BITS   = 24;

endpackage

`default_nettype wire

[hdl/tcsf_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcsf_ctrl #(
   parameter int SUM_BITS  = 33,
   parameter int DIV_STEPS = 66
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_last_pixel,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output tcsf_pkg::cmd_type     cmd
);

   localparam int STEP_BITS = $clog2(DIV_STEPS);
   localparam logic [STEP_BITS-1:0] P1_LAST  = STEP_BITS'(SUM_BITS - 1);
   localparam logic [STEP_BITS-1:0] DIV_LAST = STEP_BITS'(DIV_STEPS - 1);

   tcsf_pkg::state_type state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // State, step counter and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcsf_pkg::ST_ACC;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sequence the accumulate, multiply, divide and test phases
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         tcsf_pkg::ST_ACC: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.acc = 1'b1;
               if (req_last_pixel) begin
                  state_in = tcsf_pkg::ST_L1;
               end
            end
         end
         tcsf_pkg::ST_L1: begin
            cmd.load1 = 1'b1;
            step_in   = '0;
            state_in  = tcsf_pkg::ST_P1;
         end
         tcsf_pkg::ST_P1: begin
            cmd.step1 = 1'b1;
            if (step_ff == P1_LAST) begin
               state_in = tcsf_pkg::ST_L2;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         tcsf_pkg::ST_L2: begin
            cmd.load2 = 1'b1;
            step_in   = '0;
            state_in  = tcsf_pkg::ST_P2;
         end
         tcsf_pkg::ST_P2: begin
            cmd.step2 = 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = tcsf_pkg::ST_L3;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         tcsf_pkg::ST_L3: begin
            cmd.load3 = 1'b1;
            step_in   = '0;
            state_in  = tcsf_pkg::ST_P3;
         end
         tcsf_pkg::ST_P3: begin
            cmd.step2 = 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = tcsf_pkg::ST_PROD1;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         tcsf_pkg::ST_PROD1: begin
            cmd.prod1 = 1'b1;
            state_in  = tcsf_pkg::ST_PROD2;
         end
         tcsf_pkg::ST_PROD2: begin
            cmd.prod2 = 1'b1;
            state_in  = tcsf_pkg::ST_OUT;
         end
         tcsf_pkg::ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               cmd.clear    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = tcsf_pkg::ST_ACC;
            end
         end
         default: begin
            state_in = tcsf_pkg::ST_ACC;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[hdl/tcsf_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcsf_dpath #(
   parameter int COORD_BITS = 12,
   parameter int MAX_PIXELS = 65536
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tcsf_pkg::cmd_type             cmd,
   input  wire tcsf_pkg::csr_type             csr,
   input  wire logic [COORD_BITS-1:0]         req_px,
   input  wire logic [COORD_BITS-1:0]         req_py,
   input  wire logic [tcsf_pkg::SW_BITS-1:0]  req_stroke_width,
   input  wire logic [tcsf_pkg::COLOR_BITS-1:0] req_red,
   input  wire logic [tcsf_pkg::COLOR_BITS-1:0] req_green,
   input  wire logic [tcsf_pkg::COLOR_BITS-1:0] req_blue,
   output logic [COORD_BITS-1:0]              rsp_box_left,
   output logic [COORD_BITS-1:0]              rsp_box_top,
   output logic [COORD_BITS:0]                rsp_box_width,
   output logic [COORD_BITS:0]                rsp_box_height,
   output logic [tcsf_pkg::MEAN_BITS-1:0]     rsp_mean_width,
   output logic [tcsf_pkg::VAR_BITS-1:0]      rsp_width_variance,
   output logic [tcsf_pkg::COLOR_BITS-1:0]    rsp_mean_red,
   output logic [tcsf_pkg::COLOR_BITS-1:0]    rsp_mean_green,
   output logic [tcsf_pkg::COLOR_BITS-1:0]    rsp_mean_blue,
   output logic                               rsp_is_text
);

   localparam int CNT  = $clog2(MAX_PIXELS + 1);
   localparam int SUM  = CNT + 16;
   localparam int SQ   = CNT + 32;
   localparam int CS   = CNT + 8;
   localparam int W    = 2 * SUM;
   localparam int DV   = CNT + 8;
   localparam int WB   = COORD_BITS + 1;
   localparam int AR   = 2 * WB;
   localparam int ASP  = 16 + WB;
   localparam int FL   = 17 + AR;
   localparam int NF   = CNT + 16;
   localparam int CF   = (NF > FL) ? NF : FL;
   localparam int PV   = tcsf_pkg::VAR_BITS + 16;
   localparam int LANES = 4;
   localparam logic [CNT-1:0] CNT_MAX = CNT'(MAX_PIXELS);

   // Accumulators
   logic [CNT-1:0]        cnt_ff;
   logic [SUM-1:0]        wsum_ff;
   logic [SQ-1:0]         sq_ff;
   logic [CS-1:0]         rsum_ff, gsum_ff, bsum_ff;
   logic [COORD_BITS-1:0] minx_ff, maxx_ff, miny_ff, maxy_ff;
   logic [31:0]           sw_sq;

   assign sw_sq = {16'b0, req_stroke_width} * {16'b0, req_stroke_width};

   // Accumulate kept pixels; clear when the result is loaded
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         cnt_ff  <= '0;
         wsum_ff <= '0;
         sq_ff   <= '0;
         rsum_ff <= '0;
         gsum_ff <= '0;
         bsum_ff <= '0;
         minx_ff <= '1;
         maxx_ff <= '0;
         miny_ff <= '1;
         maxy_ff <= '0;
      end else if (cmd.acc && (cnt_ff != CNT_MAX)) begin
         cnt_ff  <= cnt_ff + 1'b1;
         wsum_ff <= wsum_ff + SUM'(req_stroke_width);
         sq_ff   <= sq_ff + SQ'(sw_sq);
         rsum_ff <= rsum_ff + CS'(req_red);
         gsum_ff <= gsum_ff + CS'(req_green);
         bsum_ff <= bsum_ff + CS'(req_blue);
         if (req_px < minx_ff) minx_ff <= req_px;
         if (req_px > maxx_ff) maxx_ff <= req_px;
         if (req_py < miny_ff) miny_ff <= req_py;
         if (req_py > maxy_ff) maxy_ff <= req_py;
      end
   end

   // Shift-add squarer for the stroke-width sum
   logic [W-1:0]   mc_ff, prod_ff;
   logic [SUM-1:0] mp_ff;

   always_ff @(posedge clock) begin
      if (cmd.load1) begin
         mc_ff   <= W'(wsum_ff);
         mp_ff   <= wsum_ff;
         prod_ff <= '0;
      end else if (cmd.step1) begin
         if (mp_ff[0]) prod_ff <= prod_ff + mc_ff;
         mc_ff <= {mc_ff[W-2:0], 1'b0};
         mp_ff <= {1'b0, mp_ff[SUM-1:1]};
      end
   end

   // Four restoring divider lanes by the pixel count: width, red, green, blue
   logic [SUM-1:0] lq_ff [LANES];
   logic [CNT-1:0] lr_ff [LANES];
   logic [SUM-1:0] lq_in [LANES];
   logic [CNT-1:0] lr_in [LANES];
   logic [CNT:0]   lrs   [LANES];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         lrs[i] = {lr_ff[i], lq_ff[i][SUM-1]};
         if (lrs[i] >= {1'b0, cnt_ff}) begin
            lr_in[i] = CNT'(lrs[i] - {1'b0, cnt_ff});
            lq_in[i] = {lq_ff[i][SUM-2:0], 1'b1};
         end else begin
            lr_in[i] = CNT'(lrs[i]);
            lq_in[i] = {lq_ff[i][SUM-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load1) begin
         lq_ff[0] <= wsum_ff;
         lq_ff[1] <= SUM'(rsum_ff);
         lq_ff[2] <= SUM'(gsum_ff);
         lq_ff[3] <= SUM'(bsum_ff);
         for (int i = 0; i < LANES; i++) lr_ff[i] <= '0;
      end else if (cmd.step1) begin
         for (int i = 0; i < LANES; i++) begin
            lq_ff[i] <= lq_in[i];
            lr_ff[i] <= lr_in[i];
         end
      end
   end

   // Wide restoring divider: square of sum by n, then residue by n*256
   logic [W-1:0]  dq_ff, dq_in, resid;
   logic [DV-1:0] dr_ff, dd_ff, dr_in;
   logic [DV:0]   drs;

   assign resid = W'(sq_ff) - dq_ff - W'(dr_ff != '0);

   always_comb begin
      drs = {dr_ff, dq_ff[W-1]};
      if (drs >= {1'b0, dd_ff}) begin
         dr_in = DV'(drs - {1'b0, dd_ff});
         dq_in = {dq_ff[W-2:0], 1'b1};
      end else begin
         dr_in = DV'(drs);
         dq_in = {dq_ff[W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load2) begin
         dq_ff <= prod_ff;
         dr_ff <= '0;
         dd_ff <= DV'(cnt_ff);
      end else if (cmd.load3) begin
         // sum of squares minus ceil(S*S/n) is n times the variance
         dq_ff <= resid;
         dr_ff <= '0;
         dd_ff <= {cnt_ff, 8'b0};
      end else if (cmd.step2) begin
         dq_ff <= dq_in;
         dr_ff <= dr_in;
      end
   end

   // First product stage: box size, aspect bounds, area, variance product
   logic [WB-1:0]  bw, bh, w_ff, h_ff;
   logic [tcsf_pkg::VAR_BITS-1:0]  var_sat, var_ff;
   logic [tcsf_pkg::MEAN_BITS-1:0] mean_ff;
   logic [AR-1:0]  area_ff;
   logic [ASP-1:0] amin_ff, amax_ff;
   logic [PV-1:0]  pv_ff;

   assign bw = {1'b0, maxx_ff} - {1'b0, minx_ff} + 1'b1;
   assign bh = {1'b0, maxy_ff} - {1'b0, miny_ff} + 1'b1;
   assign var_sat = (|dq_ff[W-1:tcsf_pkg::VAR_BITS]) ? '1 : dq_ff[tcsf_pkg::VAR_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.prod1) begin
         w_ff    <= bw;
         h_ff    <= bh;
         var_ff  <= var_sat;
         mean_ff <= lq_ff[0][tcsf_pkg::MEAN_BITS-1:0];
         area_ff <= AR'(bw) * AR'(bh);
         amin_ff <= ASP'(csr.min_aspect) * ASP'(bh);
         amax_ff <= ASP'(csr.max_aspect) * ASP'(bh);
         pv_ff   <= PV'(var_sat) * PV'(csr.var_mean_ratio);
      end
   end

   // Second product stage: occupancy bounds
   logic [FL-1:0] fmin_ff, fmax_ff;

   always_ff @(posedge clock) begin
      if (cmd.prod2) begin
         fmin_ff <= FL'(csr.min_fill) * FL'(area_ff);
         fmax_ff <= FL'(csr.max_fill) * FL'(area_ff);
      end
   end

   // Combine the tests
   logic [ASP-1:0] wa;
   logic [CF-1:0]  nf;
   logic           ok;

   always_comb begin
      wa = ASP'({w_ff, 8'b0});
      nf = CF'({cnt_ff, 16'b0});
      ok = (wa >= amin_ff) && (wa <= amax_ff)
         && (nf >= CF'(fmin_ff))
         && ((w_ff < h_ff) || (nf <= CF'(fmax_ff)))
         && (pv_ff <= PV'({mean_ff, 8'b0}));
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_box_left       <= minx_ff;
         rsp_box_top        <= miny_ff;
         rsp_box_width      <= w_ff;
         rsp_box_height     <= h_ff;
         rsp_mean_width     <= mean_ff;
         rsp_width_variance <= var_ff;
         rsp_mean_red       <= lq_ff[1][tcsf_pkg::COLOR_BITS-1:0];
         rsp_mean_green     <= lq_ff[2][tcsf_pkg::COLOR_BITS-1:0];
         rsp_mean_blue      <= lq_ff[3][tcsf_pkg::COLOR_BITS-1:0];
         rsp_is_text        <= ok;
      end
   end

endmodule

`default_nettype wire

[hdl/text_component_stats_filter.sv]
// Text component statistics filter.
// req_ channel: one pixel word per handshake (px, py, stroke_width, RGB,
// last_pixel). Pixels of a component are taken one per cycle; once
// MAX_PIXELS pixels are kept, further pixels are dropped until last_pixel.
// rsp_ channel: one result word per component (box, mean and variance of
// stroke width, mean colour, is_text).
// csr_ channel: register index and data, always ready; it is to be written
// only while idle, which the block itself does not enforce. After the last
// pixel is accepted, the result is computed by the bit-serial squarer and
// count dividers (C+16 steps, C = clog2(MAX_PIXELS+1)), two passes of the
// wide restoring divider (2*(C+16) steps each) and two product stages.
// Throughput: one pixel per cycle within a component; req_ready is low from
// the last pixel until its result is loaded into the output register.
// Stall: a waiting result holds in the output register while the next
// component's pixels are accepted; a further result waits for it.
// Reset: synchronous; clears accumulators and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

`include "text_component_stats_filter_macros.svh"

module text_component_stats_filter #(
   parameter int COORD_BITS = 12,
   parameter int MAX_PIXELS = 65536
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [COORD_BITS-1:0]              req_px,
   input  wire logic [COORD_BITS-1:0]              req_py,
   input  wire logic [tcsf_pkg::SW_BITS-1:0]       req_stroke_width,
   input  wire logic [tcsf_pkg::COLOR_BITS-1:0]    req_red,
   input  wire logic [tcsf_pkg::COLOR_BITS-1:0]    req_green,
   input  wire logic [tcsf_pkg::COLOR_BITS-1:0]    req_blue,
   input  wire logic                               req_last_pixel,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [COORD_BITS-1:0]                   rsp_box_left,
   output logic [COORD_BITS-1:0]                   rsp_box_top,
   output logic [COORD_BITS:0]                     rsp_box_width,
   output logic [COORD_BITS:0]                     rsp_box_height,
   output logic [tcsf_pkg::MEAN_BITS-1:0]          rsp_mean_width,
   output logic [tcsf_pkg::VAR_BITS-1:0]           rsp_width_variance,
   output logic [tcsf_pkg::COLOR_BITS-1:0]         rsp_mean_red,
   output logic [tcsf_pkg::COLOR_BITS-1:0]         rsp_mean_green,
   output logic [tcsf_pkg::COLOR_BITS-1:0]         rsp_mean_blue,
   output logic                                    rsp_is_text,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [tcsf_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [tcsf_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int CNT_BITS = $clog2(MAX_PIXELS + 1);
   localparam int SUM_BITS = CNT_BITS + 16;

   tcsf_pkg::csr_type csr_ff;
   tcsf_pkg::cmd_type dp_cmd;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.min_aspect     <= tcsf_pkg::RST_MIN_ASPECT;
         csr_ff.max_aspect     <= tcsf_pkg::RST_MAX_ASPECT;
         csr_ff.min_fill       <= tcsf_pkg::RST_MIN_FILL;
         csr_ff.max_fill       <= tcsf_pkg::RST_MAX_FILL;
         csr_ff.var_mean_ratio <= tcsf_pkg::RST_VAR_MEAN_RATIO;
      end else if (csr_valid) begin
         case (csr_index)
            tcsf_pkg::CSR_MIN_ASPECT:     csr_ff.min_aspect     <= csr_wdata[15:0];
            tcsf_pkg::CSR_MAX_ASPECT:     csr_ff.max_aspect     <= csr_wdata[15:0];
            tcsf_pkg::CSR_MIN_FILL:       csr_ff.min_fill       <= csr_wdata;
            tcsf_pkg::CSR_MAX_FILL:       csr_ff.max_fill       <= csr_wdata;
            tcsf_pkg::CSR_VAR_MEAN_RATIO: csr_ff.var_mean_ratio <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   tcsf_ctrl #(
      .SUM_BITS  (SUM_BITS),
      .DIV_STEPS (2 * SUM_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_pixel (req_last_pixel),
      .req_ready      (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .cmd            (dp_cmd)
   );

   tcsf_dpath #(
      .COORD_BITS (COORD_BITS),
      .MAX_PIXELS (MAX_PIXELS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (dp_cmd),
      .csr                (csr_ff),
      .req_px             (req_px),
      .req_py             (req_py),
      .req_stroke_width   (req_stroke_width),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .rsp_box_left       (rsp_box_left),
      .rsp_box_top        (rsp_box_top),
      .rsp_box_width      (rsp_box_width),
      .rsp_box_height     (rsp_box_height),
      .rsp_mean_width     (rsp_mean_width),
      .rsp_width_variance (rsp_width_variance),
      .rsp_mean_red       (rsp_mean_red),
      .rsp_mean_green     (rsp_mean_green),
      .rsp_mean_blue      (rsp_mean_blue),
      .rsp_is_text        (rsp_is_text)
   );

   // Never overwrite a result that is still waiting
   `TCSF_ASSERT_NOW(a_no_overwrite, dp_cmd.out_load, (!rsp_valid || rsp_ready), "result overwritten")
   // Stop taking pixels once a component has ended
   `TCSF_ASSERT_NEXT(a_stop_after_last, (req_valid && req_ready && req_last_pixel), !req_ready, "pixel taken during finish")
   // A new result only appears after a load
   `TCSF_ASSERT_NOW(a_valid_from_load, $rose(rsp_valid), $past(dp_cmd.out_load), "result without load")

endmodule

`default_nettype wire
